FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HCT_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("timer assertion failed");

// Concurrent assertion on the block clock clk_i and reset rst_ni.
`define HCT_ASSERT(lbl, prop) \
  `HCT_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/core/hct_pkg.sv
// Types, constants and codes shared by the timer modules.
package hct_pkg;

  localparam int MAX_TICKS  = 255;
  localparam int TICK_W     = $clog2(MAX_TICKS + 1);
  localparam int CMP_W      = (TICK_W > 8) ? TICK_W : 8;
  localparam int NUM_PRE    = 4;
  localparam int LEFT_W     = 11;
  localparam int MIN_PERIOD = 16;
  localparam int CROSS_W    = $clog2(MAX_TICKS / MIN_PERIOD + 2);

  localparam logic [LEFT_W-1:0] PERIOD [NUM_PRE] = '{11'd1024, 11'd16, 11'd64, 11'd256};
  localparam logic [3:0] PERIOD_SH [NUM_PRE] = '{4'd10, 4'd4, 4'd6, 4'd8};

  localparam logic [7:0] CTRL_RESET     = 8'hF8;
  localparam logic [7:0] CTRL_READ_MASK = 8'hF8;
  localparam int         CTRL_EN_BIT    = 2;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    SEL_DIV  = 2'd0,
    SEL_CNT  = 2'd1,
    SEL_MOD  = 2'd2,
    SEL_CTRL = 2'd3
  } sel_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic load_out;
  } hct_cmd_t;

  typedef struct packed {
    logic start_count;
    logic cnt_last;
  } hct_status_t;

endpackage

FILE: rtl/core/hct_ctrl.sv
// Controller state machine of the timer: sequences accept, counting and result hand-off.
module hct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  hct_pkg::hct_status_t status_i,
  output hct_pkg::hct_cmd_t   cmd_o
);
  import hct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_COUNT  = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.start_count ? ST_COUNT : ST_FINISH;
        end
      end
      ST_COUNT: begin
        cmd_o.step = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result moves to the output register once it is free or being taken.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/hct_dp.sv
// Datapath of the timer: registers, prescalers, counter stepping and output register.
module hct_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           req_type_i,
  input  logic [1:0]           reg_sel_i,
  input  logic [7:0]           write_data_i,
  input  logic [7:0]           tick_count_i,
  input  hct_pkg::hct_cmd_t    cmd_i,
  output hct_pkg::hct_status_t status_o,
  output logic [7:0]           read_data_o,
  output logic                 timer_irq_o
);
  import hct_pkg::*;

  logic [15:0]         div_q, div_d;
  logic [7:0]          cnt_q, cnt_d;
  logic [7:0]          mod_q, mod_d;
  logic [7:0]          ctrl_q, ctrl_d;
  logic [LEFT_W-1:0]   pre_q [NUM_PRE];
  logic [LEFT_W-1:0]   pre_d [NUM_PRE];
  logic [CROSS_W-1:0]  remain_q, remain_d;
  logic [7:0]          rd_q, rd_d;
  logic                irq_q, irq_d;
  logic [7:0]          out_rd_q;
  logic                out_irq_q;

  logic [CMP_W-1:0]    tick_ext;
  logic [TICK_W-1:0]   ticks;
  logic [LEFT_W-1:0]   ticks_ext;
  logic [TICK_W-1:0]   deficit [NUM_PRE];
  logic [LEFT_W-1:0]   left_new [NUM_PRE];
  logic [CROSS_W-1:0]  cross_cnt [NUM_PRE];
  logic [CROSS_W-1:0]  cross_sel;
  logic                timer_en;
  req_e                req;
  sel_e                sel;

  assign req      = req_e'(req_type_i);
  assign sel      = sel_e'(reg_sel_i);
  assign timer_en = ctrl_q[CTRL_EN_BIT];

  // Tick count saturation and per-prescaler advance; periods are powers of two.
  always_comb begin
    tick_ext  = CMP_W'(tick_count_i);
    ticks     = (tick_ext > CMP_W'(MAX_TICKS)) ? TICK_W'(MAX_TICKS) : TICK_W'(tick_ext);
    ticks_ext = LEFT_W'(ticks);
    for (int i = 0; i < NUM_PRE; i++) begin
      deficit[i] = '0;
      if (pre_q[i] > ticks_ext) begin
        left_new[i]  = pre_q[i] - ticks_ext;
        cross_cnt[i] = '0;
      end else begin
        deficit[i]   = TICK_W'(ticks_ext - pre_q[i]);
        cross_cnt[i] = CROSS_W'(1) + CROSS_W'(deficit[i] >> PERIOD_SH[i]);
        left_new[i]  = PERIOD[i] - LEFT_W'(deficit[i] & TICK_W'(PERIOD[i] - LEFT_W'(1)));
      end
    end
  end

  assign cross_sel            = cross_cnt[ctrl_q[1:0]];
  assign status_o.start_count = (req == REQ_TICK) && timer_en && (cross_sel != '0);
  assign status_o.cnt_last    = (remain_q == CROSS_W'(1));

  always_comb begin
    div_d    = div_q;
    cnt_d    = cnt_q;
    mod_d    = mod_q;
    ctrl_d   = ctrl_q;
    pre_d    = pre_q;
    remain_d = remain_q;
    rd_d     = rd_q;
    irq_d    = irq_q;
    if (cmd_i.accept) begin
      rd_d     = '0;
      irq_d    = 1'b0;
      remain_d = '0;
      case (req)
        REQ_TICK: begin
          div_d = div_q + 16'(ticks);
          pre_d = left_new;
          if (timer_en) begin
            remain_d = cross_sel;
          end
        end
        REQ_READ: begin
          case (sel)
            SEL_DIV:  rd_d = div_q[15:8];
            SEL_CNT:  rd_d = cnt_q;
            SEL_MOD:  rd_d = mod_q;
            SEL_CTRL: rd_d = ctrl_q | CTRL_READ_MASK;
            default:  rd_d = '0;
          endcase
        end
        REQ_WRITE: begin
          case (sel)
            SEL_DIV: begin
              div_d = '0;
              pre_d = PERIOD;
            end
            SEL_CNT:  cnt_d  = write_data_i;
            SEL_MOD:  mod_d  = write_data_i;
            SEL_CTRL: ctrl_d = write_data_i;
            default:  ctrl_d = ctrl_q;
          endcase
        end
        default: begin
          rd_d = '0;
        end
      endcase
    end else if (cmd_i.step) begin
      // One counter increment per cycle; an overflow reloads from the modulo register.
      remain_d = remain_q - CROSS_W'(1);
      if (cnt_q == 8'hFF) begin
        cnt_d = mod_q;
        irq_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= '0;
      cnt_q    <= '0;
      mod_q    <= '0;
      ctrl_q   <= CTRL_RESET;
      pre_q    <= PERIOD;
      remain_q <= '0;
    end else begin
      div_q    <= div_d;
      cnt_q    <= cnt_d;
      mod_q    <= mod_d;
      ctrl_q   <= ctrl_d;
      pre_q    <= pre_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    irq_q <= irq_d;
    if (cmd_i.load_out) begin
      out_rd_q  <= rd_q;
      out_irq_q <= irq_q;
    end
  end

  assign read_data_o = out_rd_q;
  assign timer_irq_o = out_irq_q;

endmodule

FILE: rtl/core/handheld_console_timer.sv
// Top level of the handheld console timer: controller plus datapath.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    req_type_i reg_sel_i write_data_i tick_count_i
//   out      output     out_valid_o / out_stall_i  read_data_o timer_irq_o
//
// An item takes an accept step, one counter increment per cycle, and a move to the output
// register; the increments are set by the crossings of the selected prescaler (up to 16
// for the period-16 prescaler at 255 ticks).
// Reset is asynchronous and sets the state and timer registers at once, not the result ones.
// A stalled result holds in the output register; the next item is still taken and waits
// in its final cycle until the output register is free.
module handheld_console_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [1:0] reg_sel_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] tick_count_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       timer_irq_o
);
  import hct_pkg::*;

  hct_cmd_t    cmd;
  hct_status_t status;

  hct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hct_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .reg_sel_i    (reg_sel_i),
    .write_data_i (write_data_i),
    .tick_count_i (tick_count_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .read_data_o  (read_data_o),
    .timer_irq_o  (timer_irq_o)
  );

endmodule

FILE: rtl/core/hct_chk.sv
// Port-level checker of the timer and its bind to the top level.
`include "assert_macros.svh"

module hct_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] req_type_i,
  input logic [1:0] reg_sel_i,
  input logic [7:0] write_data_i,
  input logic [7:0] tick_count_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic       timer_irq_o
);

  // A waiting result is not withdrawn.
  `HCT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  // A waiting result keeps its value.
  `HCT_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(read_data_o) && $stable(timer_irq_o))
  // Items are worked one at a time, so an accepted item blocks the next cycle.
  `HCT_ASSERT(a_one_item, in_valid_i && !in_stall_o |=> in_stall_o)
  // A new result only appears from the final cycle of an item in progress.
  `HCT_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(in_stall_o))

endmodule

bind handheld_console_timer hct_chk u_hct_chk (.*);

FILE: bench/tb_handheld_console_timer.sv
// Self-checking testbench for the handheld console timer: directed and random bus traffic.
`timescale 1ns / 100ps

module tb_handheld_console_timer;
  import hct_pkg::*;

  localparam int CYCLE_LIMIT = 250000;
  localparam int PRINT_CAP   = 40;
  localparam int tick_period [4] = '{1024, 16, 64, 256};

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } timer_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] req_type_i = 2'd0;
  logic [1:0] reg_sel_i = 2'd0;
  logic [7:0] write_data_i = 8'd0;
  logic [7:0] tick_count_i = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_data_o;
  logic       timer_irq_o;

  // Timer state as the block should hold it.
  logic [15:0] div_q;
  logic [7:0]  tima_q;
  logic [7:0]  tma_q;
  logic [7:0]  tac_q;
  int          presc_left [4];

  timer_result_t result_q [$];
  int  err_count = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;

  handheld_console_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .reg_sel_i   (reg_sel_i),
    .write_data_i(write_data_i),
    .tick_count_i(tick_count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .timer_irq_o (timer_irq_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 result_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= PRINT_CAP) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic void clear_divider();
    div_q = 16'd0;
    for (int i = 0; i < 4; i++) begin
      presc_left[i] = tick_period[i];
    end
  endfunction

  // Applies one accepted item to the timer state and queues the result it must produce.
  function automatic void predict_item(req_e req, sel_e sel, logic [7:0] wdata,
                                       logic [7:0] ticks);
    timer_result_t res;
    int            crossings [4];
    int            deficit;
    int            t;
    res = '0;
    t = int'(ticks);
    case (req)
      REQ_TICK: begin
        div_q = div_q + 16'(t);
        for (int i = 0; i < 4; i++) begin
          if (presc_left[i] > t) begin
            presc_left[i] -= t;
            crossings[i] = 0;
          end else begin
            deficit = t - presc_left[i];
            crossings[i] = 1 + deficit / tick_period[i];
            presc_left[i] = tick_period[i] - (deficit % tick_period[i]);
          end
        end
        if (tac_q[2]) begin
          for (int k = 0; k < crossings[tac_q[1:0]]; k++) begin
            tima_q = tima_q + 8'd1;
            if (tima_q == 8'd0) begin
              tima_q = tma_q;
              res.timer_irq = 1'b1;
            end
          end
        end
      end
      REQ_READ: begin
        case (sel)
          SEL_DIV: res.read_data = div_q[15:8];
          SEL_CNT: res.read_data = tima_q;
          SEL_MOD: res.read_data = tma_q;
          default: res.read_data = tac_q | 8'hF8;
        endcase
      end
      REQ_WRITE: begin
        case (sel)
          SEL_DIV: clear_divider();
          SEL_CNT: tima_q = wdata;
          SEL_MOD: tma_q = wdata;
          default: tac_q = wdata;
        endcase
      end
      default: ;
    endcase
    result_q.push_back(res);
  endfunction

  // Valid stays high from one item to the next unless an idle burst or a drain comes between them.
  task automatic send_item(req_e req, sel_e sel, logic [7:0] wdata, logic [7:0] ticks);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    reg_sel_i    <= sel;
    write_data_i <= wdata;
    tick_count_i <= ticks;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(req, sel, wdata, ticks);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    wait (result_q.size() == 0);
    @(posedge clk_i);
  endtask

  // Checks every result and stalls the output side in random bursts while idle_on is set.
  initial begin : result_monitor
    timer_result_t want;
    int            stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result rd=%02h irq=%0b", read_data_o,
                                    timer_irq_o));
        end else begin
          want = result_q.pop_front();
          if (read_data_o !== want.read_data) begin
            report_mismatch($sformatf("read_data %02h, expected %02h", read_data_o,
                                      want.read_data));
          end
          if (timer_irq_o !== want.timer_irq) begin
            report_mismatch($sformatf("timer_irq %0b, expected %0b", timer_irq_o,
                                      want.timer_irq));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_reset_reads();
    send_item(REQ_READ, SEL_DIV, 8'h00, 8'h00);
    send_item(REQ_READ, SEL_CNT, 8'h00, 8'h00);
    send_item(REQ_READ, SEL_MOD, 8'h00, 8'h00);
    send_item(REQ_READ, SEL_CTRL, 8'h00, 8'h00);
  endtask

  task automatic test_register_access();
    send_item(REQ_WRITE, SEL_CTRL, 8'hFF, 8'h00);
    send_item(REQ_READ, SEL_CTRL, 8'h00, 8'hFF);
    send_item(REQ_WRITE, SEL_MOD, 8'hFF, 8'hFF);
    send_item(REQ_READ, SEL_MOD, 8'hFF, 8'h00);
    send_item(REQ_WRITE, SEL_CNT, 8'h00, 8'h00);
    send_item(REQ_READ, SEL_CNT, 8'h00, 8'h00);
    // The unused request code must leave everything untouched.
    send_item(REQ_NONE, SEL_CTRL, 8'hFF, 8'hFF);
  endtask

  task automatic test_tick_edges();
    send_item(REQ_WRITE, SEL_CTRL, 8'h05, 8'h00);
    send_item(REQ_WRITE, SEL_MOD, 8'hFF, 8'h00);
    send_item(REQ_WRITE, SEL_CNT, 8'hFE, 8'h00);
    send_item(REQ_TICK, SEL_DIV, 8'h00, 8'h00);
    // With the modulo at all ones every crossing past the first overflows again.
    send_item(REQ_TICK, SEL_DIV, 8'h00, 8'hFF);
    send_item(REQ_READ, SEL_CNT, 8'h00, 8'h00);
    send_item(REQ_WRITE, SEL_CTRL, 8'h00, 8'h00);
    send_item(REQ_TICK, SEL_CNT, 8'h00, 8'hFF);
    send_item(REQ_READ, SEL_DIV, 8'h00, 8'h00);
    send_item(REQ_WRITE, SEL_DIV, 8'hA5, 8'h00);
    send_item(REQ_READ, SEL_DIV, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(int n_items);
    int         pick;
    req_e       req;
    sel_e       sel;
    logic [7:0] wdata;
    logic [7:0] ticks;
    for (int n = 0; n < n_items; n++) begin
      pick  = $urandom_range(0, 99);
      sel   = sel_e'($urandom_range(0, 3));
      wdata = 8'($urandom_range(0, 255));
      ticks = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 40))
                                          : 8'($urandom_range(0, 255));
      if (pick < 50) begin
        req = REQ_TICK;
      end else if (pick < 72) begin
        req = REQ_READ;
      end else if (pick < 96) begin
        req = REQ_WRITE;
        // Divider clears stay rare so the prescalers get to run long stretches.
        if (sel == SEL_DIV && $urandom_range(0, 3) != 0) begin
          sel = SEL_CTRL;
        end
        if (sel == SEL_CNT && $urandom_range(0, 1) == 0) begin
          wdata = 8'($urandom_range(8'hF0, 8'hFF));
        end
      end else begin
        req = REQ_NONE;
      end
      send_item(req, sel, wdata, ticks);
    end
  endtask

  task automatic test_drain_pause();
    drain_results();
    test_random_traffic(20);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_traffic(150);
  endtask

  initial begin
    div_q  = 16'd0;
    tima_q = 8'd0;
    tma_q  = 8'd0;
    tac_q  = 8'hF8;
    clear_divider();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_reads();
    test_register_access();
    test_tick_edges();
    test_random_traffic(380);
    test_drain_pause();
    test_random_traffic(280);
    test_back_to_back();

    drain_results();
    repeat (25) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
